@@ hw/rtl/lpsd_pkg.sv @@
// Shared types, request codes and constants of the LED panel scan driver.
package lpsd_pkg;

  // Request codes carried in the input tuser field
  localparam logic [1:0] REQ_PIXEL = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  // Configuration register indexes
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  // Reset values of the size registers
  localparam logic [5:0] WIDTH_RST  = 6'd32;
  localparam logic [4:0] HEIGHT_RST = 5'd16;

  // Flipped row value, quotient and remainder widths of the row divider
  localparam int FY_W  = 5;
  localparam int QUO_W = 5;
  localparam int REM_W = 4;

  // Row-select line patterns, indexed by scan row modulo 4
  localparam logic [3:0] SEL_A_TBL = 4'b1010;
  localparam logic [3:0] SEL_B_TBL = 4'b0110;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PIX_DIV,
    ST_PIX_WR,
    ST_TICK_RD,
    ST_TICK_SHIFT
  } state_t;

  // Status of the serial row divider
  typedef struct packed {
    logic             done;
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] quo;
  } div_res_t;

  // Status of the bit shifter
  typedef struct packed {
    logic done;
    logic dout;
  } shf_res_t;

endpackage

@@ hw/rtl/lpsd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module lpsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hw/rtl/lpsd_div.sv @@
// Bit-serial restoring divider: splits the flipped row into scan row and byte group.
module lpsd_div
  import lpsd_pkg::*;
#(
  parameter int SCAN_ROWS = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start_i,
  input  logic [FY_W-1:0] fy_i,
  output div_res_t        res_o
);

  localparam logic [FY_W-1:0] DIV_C = FY_W'(SCAN_ROWS);

  logic             busy_r, busy_nxt;
  logic [2:0]       cnt_r, cnt_nxt;
  logic [FY_W-1:0]  dvd_r, dvd_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [QUO_W-1:0] quo_r, quo_nxt;
  logic [FY_W-1:0]  trial;
  logic             ge;
  logic             done;

  // One quotient bit per cycle, dividend bits enter MSB first
  assign trial = {rem_r, dvd_r[FY_W-1]};
  assign ge    = (trial >= DIV_C);
  assign done  = busy_r && (cnt_r == 3'd0);

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start_i) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 3'(FY_W);
      dvd_nxt  = fy_i;
      rem_nxt  = '0;
      quo_nxt  = '0;
    end else if (done) begin
      busy_nxt = 1'b0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r - 3'd1;
      dvd_nxt = {dvd_r[FY_W-2:0], 1'b0};
      rem_nxt = ge ? REM_W'(trial - DIV_C) : trial[REM_W-1:0];
      quo_nxt = {quo_r[QUO_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign res_o.done = done;
  assign res_o.rem  = rem_r;
  assign res_o.quo  = quo_r;

endmodule

@@ hw/rtl/lpsd_shift.sv @@
// Byte shift register that walks a frame byte down to the requested bit.
module lpsd_shift
  import lpsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load_i,
  input  logic [7:0] data_i,
  input  logic [2:0] cnt_i,
  input  logic       take_i,
  output shf_res_t   res_o
);

  logic       busy_r, busy_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [7:0] sh_r, sh_nxt;
  logic       done;

  assign done = busy_r && (cnt_r == 3'd0);

  // Shift right one bit per cycle until the wanted bit sits at bit 0
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    sh_nxt   = sh_r;
    if (load_i) begin
      busy_nxt = 1'b1;
      cnt_nxt  = cnt_i;
      sh_nxt   = data_i;
    end else if (done) begin
      if (take_i) begin
        busy_nxt = 1'b0;
      end
    end else if (busy_r) begin
      cnt_nxt = cnt_r - 3'd1;
      sh_nxt  = {1'b0, sh_r[7:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    sh_r <= sh_nxt;
  end

  assign res_o.done = done;
  assign res_o.dout = sh_r[0];

endmodule

@@ hw/rtl/led_panel_frame_scan_driver.sv @@
// Scan tick: frame RAM read, bit shifter load, shift down to bit k = bit index within byte (0..7),
// then the result is registered once the output register is free. Pixel write: 5-step serial
// row divider, frame RAM read, then write, both skipped for a byte beyond the row. Clear, ignored
// pixel and unused code stay idle; a waiting tick result does not block input.
// Reset (synchronous, rst_n low): store reads as zero via per-byte valid bits, scan position 0,
// width 32, height 16; no clearing pass is needed.
module led_panel_frame_scan_driver
  import lpsd_pkg::*;
#(
  parameter int SCAN_ROWS     = 4,
  parameter int BYTES_PER_ROW = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // Request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // pixel_x [7:0], pixel_y [15:8], pixel_color [31:16]
  input  logic [1:0]  in_tuser,   // req_type [1:0]
  // Result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // serial_data [0], row_sel_a [1], row_sel_b [2], zeros [7:3]
  output logic        out_tlast,  // latch_pulse
  // Configuration write port
  input  logic        cfg_wr_en,
  input  logic        cfg_addr,
  input  logic [5:0]  cfg_wdata
);

  localparam int DEPTH  = SCAN_ROWS * BYTES_PER_ROW;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int ROW_W  = $clog2(SCAN_ROWS);
  localparam int BITS   = BYTES_PER_ROW * 8;
  localparam int BIT_W  = $clog2(BITS);
  localparam logic [ADDR_W-1:0] BPR_A    = ADDR_W'(BYTES_PER_ROW);
  localparam logic [ROW_W-1:0]  ROW_LAST = ROW_W'(SCAN_ROWS - 1);
  localparam logic [BIT_W-1:0]  BIT_LAST = BIT_W'(BITS - 1);

  // Control state
  state_t             state_r, state_nxt;
  logic [5:0]         width_r, width_nxt;
  logic [4:0]         height_r, height_nxt;
  logic [ROW_W-1:0]   scan_row_r, scan_row_nxt;
  logic [BIT_W-1:0]   scan_bit_r, scan_bit_nxt;
  logic [DEPTH-1:0]   vld_r, vld_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Payload captured per request
  logic [2:0]         xb_r, bidx_r, tick_bit_r;
  logic               on_r, pix_vld_r, tick_vld_r;
  logic [ADDR_W-1:0]  pix_addr_r;
  logic               tick_sela_r, tick_selb_r, tick_last_r;
  logic [2:0]         out_data_r;
  logic               out_last_r;

  // Request decode
  logic               in_fire;
  logic [1:0]         req;
  logic [7:0]         px, py;
  logic               pix_ok;
  logic [FY_W-1:0]    fy;

  // Address arithmetic
  logic [5:0]         col;
  logic               col_ok;
  logic [ADDR_W-1:0]  pix_addr, tick_addr;
  logic [1:0]         row2;

  // Datapath controls
  logic               rd_en, wr_en, div_start, shf_load, shf_take, out_load;
  logic [ADDR_W-1:0]  rd_addr;
  logic [7:0]         rd_data, old_byte, new_byte, mask;
  div_res_t           div_res;
  shf_res_t           shf_res;

  assign in_fire = in_tvalid && in_tready;
  assign req     = in_tuser;
  assign px      = in_tdata[7:0];
  assign py      = in_tdata[15:8];
  assign pix_ok  = (px < {2'b00, width_r}) && (py < {3'b000, height_r});
  assign fy      = height_r - 5'd1 - py[4:0];

  // Byte position of a pixel: column group times stride plus row group
  assign col      = {1'b0, xb_r, 2'b00} + {1'b0, div_res.quo};
  assign col_ok   = ({1'b0, col} < 7'(BYTES_PER_ROW));
  assign pix_addr = ADDR_W'(div_res.rem[ROW_W-1:0]) * BPR_A + ADDR_W'(col);
  assign tick_addr = ADDR_W'(scan_row_r) * BPR_A + ADDR_W'(scan_bit_r[BIT_W-1:3]);
  assign row2      = 2'(scan_row_r);

  // Read-modify-write of one frame bit
  assign old_byte = pix_vld_r ? rd_data : 8'd0;
  assign mask     = 8'd1 << bidx_r;
  assign new_byte = on_r ? (old_byte | mask) : (old_byte & ~mask);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (req == REQ_PIXEL && pix_ok) begin
            state_nxt = ST_PIX_DIV;
          end else if (req == REQ_TICK) begin
            state_nxt = ST_TICK_RD;
          end
        end
      end
      ST_PIX_DIV: begin
        if (div_res.done) begin
          state_nxt = col_ok ? ST_PIX_WR : ST_IDLE;
        end
      end
      ST_PIX_WR:  state_nxt = ST_IDLE;
      ST_TICK_RD: state_nxt = ST_TICK_SHIFT;
      ST_TICK_SHIFT: begin
        if (shf_res.done && (!out_valid_r || out_tready)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_tready = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = tick_addr;
    wr_en     = 1'b0;
    div_start = 1'b0;
    shf_load  = 1'b0;
    shf_take  = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        div_start = in_fire && (req == REQ_PIXEL) && pix_ok;
        rd_en     = in_fire && (req == REQ_TICK);
      end
      ST_PIX_DIV: begin
        rd_en   = div_res.done && col_ok;
        rd_addr = pix_addr;
      end
      ST_PIX_WR:  wr_en = 1'b1;
      ST_TICK_RD: shf_load = 1'b1;
      ST_TICK_SHIFT: begin
        out_load = shf_res.done && (!out_valid_r || out_tready);
        shf_take = out_load;
      end
      default: in_tready = 1'b0;
    endcase
  end

  // Configuration, scan position, valid bits and output handshake
  always_comb begin
    width_nxt     = width_r;
    height_nxt    = height_r;
    scan_row_nxt  = scan_row_r;
    scan_bit_nxt  = scan_bit_r;
    vld_nxt       = vld_r;
    out_valid_nxt = out_valid_r;
    if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_WIDTH:  width_nxt  = cfg_wdata;
        CFG_HEIGHT: height_nxt = cfg_wdata[4:0];
        default:    width_nxt  = width_r;
      endcase
    end
    if (in_fire && req == REQ_TICK) begin
      if (scan_bit_r == BIT_LAST) begin
        scan_bit_nxt = '0;
        scan_row_nxt = (scan_row_r == ROW_LAST) ? '0 : scan_row_r + ROW_W'(1);
      end else begin
        scan_bit_nxt = scan_bit_r + BIT_W'(1);
      end
    end
    if (in_fire && req == REQ_CLEAR) begin
      vld_nxt = '0;
    end else if (wr_en) begin
      vld_nxt[pix_addr_r] = 1'b1;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      width_r     <= WIDTH_RST;
      height_r    <= HEIGHT_RST;
      scan_row_r  <= '0;
      scan_bit_r  <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      scan_row_r  <= scan_row_nxt;
      scan_bit_r  <= scan_bit_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Per-request payload capture
  always_ff @(posedge clk) begin
    if (div_start) begin
      xb_r   <= px[5:3];
      bidx_r <= px[2:0];
      on_r   <= |in_tdata[31:16];
    end
    if (rd_en && state_r == ST_PIX_DIV) begin
      pix_addr_r <= pix_addr;
      pix_vld_r  <= vld_r[pix_addr];
    end
    if (rd_en && state_r == ST_IDLE) begin
      tick_vld_r  <= vld_r[tick_addr];
      tick_bit_r  <= scan_bit_r[2:0];
      tick_sela_r <= SEL_A_TBL[row2];
      tick_selb_r <= SEL_B_TBL[row2];
      tick_last_r <= (scan_bit_r == BIT_LAST);
    end
    if (out_load) begin
      out_data_r <= {tick_selb_r, tick_sela_r, ~shf_res.dout};
      out_last_r <= tick_last_r;
    end
  end

  lpsd_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_frame_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (pix_addr_r),
    .wr_data (new_byte),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  lpsd_div #(
    .SCAN_ROWS (SCAN_ROWS)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (div_start),
    .fy_i    (fy),
    .res_o   (div_res)
  );

  lpsd_shift u_shift (
    .clk    (clk),
    .rst_n  (rst_n),
    .load_i (shf_load),
    .data_i (tick_vld_r ? rd_data : 8'd0),
    .cnt_i  (tick_bit_r),
    .take_i (shf_take),
    .res_o  (shf_res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b00000, out_data_r};
  assign out_tlast  = out_last_r;

  // A scan tick always moves on to the frame read
  a_tick_reads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && req == REQ_TICK) |=> (state_r == ST_TICK_RD))
    else $error("tick request did not start a frame read");

  // Clear leaves every byte reading as zero
  a_clear_all: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && req == REQ_CLEAR) |=> (vld_r == '0))
    else $error("clear left valid bytes");

  // The latch bit wraps the bit counter
  a_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && req == REQ_TICK && scan_bit_r == BIT_LAST) |=> (scan_bit_r == '0))
    else $error("bit counter did not wrap at row end");

  // The divider remainder is a legal scan row whenever the divider is done
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> ({1'b0, div_res.rem} < 5'(SCAN_ROWS)))
    else $error("row divider remainder out of range");

  // A result never overwrites one not yet taken
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_tready))
    else $error("output register overrun");

endmodule
